>>> hw/rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants for the packet flow statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none
package pfs_pkg;
  localparam logic [31:0] IntervalReset = 32'd250000;
  localparam logic [31:0] UsPerSec      = 32'd1000000;

  typedef enum logic {FUNC_RECORD = 1'b0, FUNC_UPDATE = 1'b1} func_e;

  // one divider request
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> hw/rtl/packet_flow_statistics_unit.sv
// ----------------------------------------------------------------------------
// packet_flow_statistics_unit
// Two-flow packet statistics over frame rings held in one slot memory.
// ----------------------------------------------------------------------------
// Usage: pulse start with an item while busy is low. The item is taken
// at that edge; busy stays high until the single result, marked by
// result_valid_o for one cycle. Results cannot be held off.
// The interval register is written on cfg_valid_i && cfg_ready_o.
// Steps from transfer to result strobe: a record whose sequence number
// does not advance goes through acknowledge read, wait, write and output;
// one that advances first writes the ring slots up to its own (at most
// FRAME_SLOTS), then its own slot, one slot write per cycle on the memory
// port, before those steps. An update without recompute goes straight to
// output; with one, a ring scan and up to three divisions on the shared
// bit-serial divider precede the loss and choke folds. One item is in
// flight at a time; a new item is taken only once busy is low again.
// At reset the slot memory is cleared by a pass over all 2*FRAME_SLOTS
// slots during which busy stays high; the per-flow registers reset at once.
// ----------------------------------------------------------------------------
`default_nettype none
module packet_flow_statistics_unit import pfs_pkg::*; #(
  parameter int FRAME_SLOTS = 128,
  parameter int TIME_BITS   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        func_i,
  input  wire logic        flow_dir_i,
  input  wire logic [31:0] now_us_i,
  input  wire logic [30:0] seq_nr_i,
  input  wire logic [30:0] ack_nr_i,
  input  wire logic [7:0]  choked_count_i,
  input  wire logic [7:0]  dropped_count_i,
  input  wire logic [15:0] size_bytes_i,
  output logic             result_valid_o,
  output logic             stats_updated_o,
  output logic [31:0]      last_latency_us_o,
  output logic [31:0]      avg_latency_us_o,
  output logic [31:0]      avg_bytes_per_sec_o,
  output logic [31:0]      avg_packets_per_sec_o,
  output logic [15:0]      avg_loss_o,
  output logic [15:0]      avg_choke_o,
  output logic [31:0]      total_bytes_o,
  output logic [31:0]      total_packets_o
);
  localparam int SB = $clog2(FRAME_SLOTS);
  localparam int AB = SB + 1;
  localparam int CB = SB + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
  localparam logic [31:0] FS32 = 32'(FRAME_SLOTS);

  // slot word: time, valid, size, latency, acked, choked, dropped
  typedef struct packed {
    logic [TIME_BITS-1:0] tm;
    logic                 vld;
    logic [15:0]          sz;
    logic [31:0]          lat;
    logic                 ack;
    logic [7:0]           ch;
    logic [7:0]           dr;
  } slot_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_GAP, S_LAST, S_ARD, S_AWAIT, S_AWR, S_UPD, S_SCAN, S_SWAIT,
    S_DB, S_DBW, S_DP, S_DPW, S_DL, S_DLW, S_DFL, S_DFC, S_OUT
  } state_e;

  slot_t mem [2*FRAME_SLOTS];
  slot_t rd_q;
  logic  wr_en, rd_en;
  logic [AB-1:0] wr_addr, rd_addr;
  slot_t wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  state_e st_q;
  logic [31:0] interval_q;
  logic [30:0] cur_q [2];
  logic [31:0] bytes_q [2], pkts_q [2], abr_q [2], apr_q [2], llat_q [2], alat_q [2];
  logic [TIME_BITS-1:0] next_q [2];
  logic [15:0] aloss_q [2], achk_q [2];

  logic f_q, upd_q;
  logic [TIME_BITS-1:0] now_q;
  logic [30:0] seq_q, ack_q;
  logic [7:0] ch_q, dr_q;
  logic [15:0] sz_q;
  logic [SB:0] b_q;
  logic [AB-1:0] clr_q;
  logic [SB:0] idx_q;
  logic        pend_q;
  logic [CB-1:0] vcnt_q, lcnt_q;
  logic [SB+8:0] chs_q;
  logic [SB+16:0] bsum_q;
  logic [SB+32:0] lsum_q;
  logic [TIME_BITS-1:0] tmin_q, tmax_q;

  div_req_t dreq;
  div_rsp_t drsp;
  pfs_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [SB-1:0] gap_slot;
  logic [30:0] gap_seq;
  logic [8:0]  chdr;
  logic [TIME_BITS:0] nx;
  logic [TIME_BITS-1:0] dspan;
  logic [31:0] quo_sat;
  logic [63:0] sat_src;

  assign gap_seq  = seq_q - 31'(b_q);
  assign gap_slot = gap_seq[SB-1:0];
  assign chdr     = {1'b0, ch_q} + {1'b0, dr_q};
  assign nx       = {1'b0, now_q} + (TIME_BITS + 1)'(interval_q);
  assign dspan    = tmax_q - tmin_q;
  assign sat_src  = drsp.quo;
  assign quo_sat  = (|sat_src[63:32]) ? 32'hFFFF_FFFF : sat_src[31:0];

  // ewma fold; the fractional folds follow below
  function automatic logic [31:0] ewma(input logic [31:0] a, input logic [31:0] s);
    logic [34:0] t;
    t = ({3'b0, a} * 35'd3 + {3'b0, s} + 35'd2) >> 2;
    return t[31:0];
  endfunction

  // loss or choke numerator N, signed; the fold divides N + 2T by 4T with a shift
  logic signed [63:0] fnum;
  logic signed [63:0] fdelta;
  logic [15:0] favg;
  always_comb begin
    favg   = (st_q == S_DFL) ? aloss_q[f_q] : achk_q[f_q];
    fdelta = (st_q == S_DFL) ?
             (64'(FRAME_SLOTS) - 64'(vcnt_q) - 64'(chs_q)) : 64'(chs_q);
    fnum   = 64'(favg) * 64'(3 * FRAME_SLOTS) + (fdelta <<< 16);
  end
  logic [63:0] fsum;
  logic [15:0] fres;
  assign fsum = fnum + 64'(2 * FRAME_SLOTS);
  assign fres = (|fsum[63:SB+18]) ? 16'hFFFF : fsum[SB+17:SB+2];

  logic acc_in;
  assign acc_in = start && !busy;
  assign busy = (st_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // memory port control
  always_comb begin
    wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    rd_en = 1'b0; rd_addr = '0;
    unique case (st_q)
      S_CLR: begin
        wr_en = 1'b1; wr_addr = clr_q;
      end
      S_GAP: begin
        wr_en = 1'b1; wr_addr = {f_q, gap_slot};
        wr_data.tm = now_q;
        wr_data.ch = {7'b0, (9'(b_q) < {1'b0, ch_q})};
        wr_data.dr = {7'b0, !(9'(b_q) < {1'b0, ch_q}) && (9'(b_q) < chdr)};
      end
      S_LAST: begin
        wr_en = 1'b1; wr_addr = {f_q, seq_q[SB-1:0]};
        wr_data.tm = now_q; wr_data.vld = 1'b1; wr_data.sz = sz_q;
        wr_data.ch = ch_q; wr_data.dr = dr_q;
      end
      S_ARD: begin
        rd_en = 1'b1; rd_addr = {~f_q, ack_q[SB-1:0]};
      end
      S_AWR: begin
        wr_en = rd_q.vld && !rd_q.ack &&
                ({1'b0, ack_q} + 32'(FRAME_SLOTS) > {1'b0, cur_q[~f_q]});
        wr_addr = {~f_q, ack_q[SB-1:0]};
        wr_data = rd_q;
        wr_data.ack = 1'b1;
        wr_data.lat = (now_q >= rd_q.tm) ?
                      (((TIME_BITS > 32) && |(64'(now_q - rd_q.tm) >> 32)) ?
                       32'hFFFF_FFFF : 32'(now_q - rd_q.tm)) : 32'd0;
      end
      S_SCAN: begin
        rd_en = !idx_q[SB]; rd_addr = {f_q, idx_q[SB-1:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    dreq.start = 1'b0; dreq.num = '0; dreq.den = 64'd1;
    unique case (st_q)
      S_DB: begin
        dreq.start = 1'b1; dreq.num = 64'(bsum_q) * 64'(UsPerSec);
        dreq.den = 64'(dspan);
      end
      S_DP: begin
        dreq.start = 1'b1; dreq.num = 64'(vcnt_q) * 64'(UsPerSec) * 64'd256;
        dreq.den = 64'(dspan);
      end
      S_DL: begin
        dreq.start = (lcnt_q != '0); dreq.num = 64'(lsum_q); dreq.den = 64'(lcnt_q);
      end
      default: ;
    endcase
  end

  // control sequencer with registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; interval_q <= IntervalReset;
      result_valid_o <= 1'b0; stats_updated_o <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        cur_q[i] <= '0; bytes_q[i] <= '0; pkts_q[i] <= '0; next_q[i] <= '0;
        abr_q[i] <= '0; apr_q[i] <= '0; llat_q[i] <= '0; alat_q[i] <= '0;
        aloss_q[i] <= '0; achk_q[i] <= '0;
      end
      f_q <= 1'b0; upd_q <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_valid_i) interval_q <= cfg_data_i;
      unique case (st_q)
        S_CLR: begin
          clr_q <= clr_q + AB'(1);
          if (clr_q == AB'(2*FRAME_SLOTS-1)) st_q <= S_IDLE;
        end
        S_IDLE: if (acc_in) begin
          f_q <= flow_dir_i; upd_q <= 1'b0;
          if (func_i == FUNC_RECORD) begin
            pkts_q[flow_dir_i] <= pkts_q[flow_dir_i] + 32'd1;
            if (seq_nr_i > cur_q[flow_dir_i]) begin
              st_q <= S_GAP;
              b_q  <= ({1'b0, seq_nr_i} - {1'b0, cur_q[flow_dir_i]} >= FS32) ?
                      (SB+1)'(FRAME_SLOTS - 1) :
                      (SB+1)'(seq_nr_i - cur_q[flow_dir_i] - 31'd1);
            end else begin
              st_q <= S_ARD;
              cur_q[flow_dir_i] <= seq_nr_i;
            end
          end else begin
            bytes_q[flow_dir_i] <= bytes_q[flow_dir_i] + 32'(size_bytes_i);
            st_q <= S_UPD;
          end
        end
        S_GAP: begin
          if (b_q == '0) st_q <= S_LAST;
          else b_q <= b_q - (SB+1)'(1);
        end
        S_LAST: begin
          cur_q[f_q] <= seq_q; st_q <= S_ARD;
        end
        S_ARD: st_q <= S_AWAIT;
        S_AWAIT: st_q <= S_AWR;
        S_AWR: st_q <= S_OUT;
        S_UPD: begin
          if (next_q[f_q] <= now_q) begin
            next_q[f_q] <= nx[TIME_BITS] ? TMAX : nx[TIME_BITS-1:0];
            upd_q <= 1'b1; idx_q <= '0; pend_q <= 1'b0;
            vcnt_q <= '0; lcnt_q <= '0; chs_q <= '0; bsum_q <= '0; lsum_q <= '0;
            st_q <= S_SCAN;
          end else st_q <= S_OUT;
        end
        S_SCAN: begin
          // accumulate the slot read last cycle
          pend_q <= !idx_q[SB];
          if (!idx_q[SB]) idx_q <= idx_q + (SB+1)'(1);
          if (pend_q && rd_q.vld) begin
            if (vcnt_q == '0 || rd_q.tm < tmin_q) tmin_q <= rd_q.tm;
            if (vcnt_q == '0 || rd_q.tm > tmax_q) tmax_q <= rd_q.tm;
            vcnt_q <= vcnt_q + CB'(1);
            chs_q  <= chs_q + (SB+9)'(rd_q.ch);
            bsum_q <= bsum_q + (SB+17)'(rd_q.sz);
            if (rd_q.ack) begin
              lsum_q <= lsum_q + (SB+33)'(rd_q.lat);
              lcnt_q <= lcnt_q + CB'(1);
            end
          end
          if (idx_q[SB] && !pend_q) st_q <= S_SWAIT;
        end
        S_SWAIT: st_q <= (vcnt_q != '0 && tmax_q > tmin_q) ? S_DB : S_DL;
        S_DB: st_q <= S_DBW;
        S_DBW: if (drsp.done) begin
          abr_q[f_q] <= ewma(abr_q[f_q], quo_sat); st_q <= S_DP;
        end
        S_DP: st_q <= S_DPW;
        S_DPW: if (drsp.done) begin
          apr_q[f_q] <= ewma(apr_q[f_q], quo_sat); st_q <= S_DL;
        end
        S_DL: st_q <= (lcnt_q != '0) ? S_DLW : S_DFL;
        S_DLW: if (drsp.done) begin
          llat_q[f_q] <= quo_sat; alat_q[f_q] <= ewma(alat_q[f_q], quo_sat);
          st_q <= S_DFL;
        end
        S_DFL: begin
          if (fnum > 0) aloss_q[f_q] <= fres;
          else aloss_q[f_q] <= '0;
          st_q <= S_DFC;
        end
        S_DFC: begin
          if (fnum > 0) achk_q[f_q] <= fres;
          else achk_q[f_q] <= '0;
          st_q <= S_OUT;
        end
        S_OUT: begin
          result_valid_o <= 1'b1; stats_updated_o <= upd_q; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      now_q <= TIME_BITS'(now_us_i); seq_q <= seq_nr_i; ack_q <= ack_nr_i;
      ch_q <= choked_count_i; dr_q <= dropped_count_i; sz_q <= size_bytes_i;
    end
  end

  assign last_latency_us_o     = llat_q[f_q];
  assign avg_latency_us_o      = alat_q[f_q];
  assign avg_bytes_per_sec_o   = abr_q[f_q];
  assign avg_packets_per_sec_o = apr_q[f_q];
  assign avg_loss_o            = aloss_q[f_q];
  assign avg_choke_o           = achk_q[f_q];
  assign total_bytes_o         = bytes_q[f_q];
  assign total_packets_o       = pkts_q[f_q];
endmodule
`default_nettype wire

>>> hw/rtl/pfs_div.sv
// ----------------------------------------------------------------------------
// pfs_div
// Restoring divider, one quotient bit per cycle, 64 by 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module pfs_div import pfs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  logic [63:0] rem_q, quo_q, den_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] trial;

  assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

  // shift one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[62:0], quo_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule
`default_nettype wire

>>> hw/rtl/pfs_checker.sv
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks of the packet flow statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none
module pfs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid_o
);
  // an accepted item makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("not busy after transfer");
  // a result ends the busy period
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy) else $error("busy during result");
  // a strobe lasts one cycle
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("long strobe");
  // results come only after work
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("spurious result");
endmodule

bind packet_flow_statistics_unit pfs_checker u_pfs_checker (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o
);
`default_nettype wire
